### src/tcpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcpq_pkg;

	localparam int DEPTH    = 16;
	localparam int TAG_BITS = 16;
	localparam int KEY_W    = 8;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int OCC_W    = $clog2(DEPTH + 1);
	localparam int ENTRY_W  = KEY_W + TAG_BITS;

	localparam logic [KEY_W-1:0] THRESHOLD_RESET = 8'd65;

	// Register index taken from paddr[2].
	localparam logic REG_THRESHOLD = 1'b0;

	typedef enum logic [0:0] {
		CMD_ENQUEUE = 1'b0,
		CMD_DEQUEUE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_ENQUEUED = 2'd0,
		ST_DEQUEUED = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef struct packed {
		cmd_t                cmd;
		logic [KEY_W-1:0]    item_key;
		logic [TAG_BITS-1:0] item_tag;
	} in_item_t;

	typedef struct packed {
		status_t             status;
		logic [TAG_BITS-1:0] out_tag;
		logic [KEY_W-1:0]    out_key;
		logic [OCC_W-1:0]    occupancy;
	} out_item_t;

	typedef struct packed {
		logic      valid;
		out_item_t item;
	} res_push_t;

	function automatic logic [ADDR_W-1:0] next_ptr(input logic [ADDR_W-1:0] p);
		return (p == ADDR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

endpackage

`default_nettype wire

### src/tcpq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tcpq_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16,
	localparam int AW   = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### src/tcpq_resq.sv
`timescale 1ns / 1ps
`default_nettype none

module tcpq_resq (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire tcpq_pkg::res_push_t   push,
	output logic                       ready,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output tcpq_pkg::out_item_t        out_data
);

	import tcpq_pkg::*;

	out_item_t  ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = ent_q[rd_q];
	assign pop       = out_valid && !out_stall;
	assign ready     = (cnt_q != 2'd2);

	always_ff @(posedge clk) begin
		if (push.valid) begin
			ent_q[wr_q] <= push.item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push.valid) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push.valid} - {1'b0, pop};
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> cnt_q != 2'd2)
		else $error("Result queue written while full.");
`endif

endmodule

`default_nettype wire

### src/tcpq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tcpq_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire tcpq_pkg::in_item_t          in_data,
	input  wire logic [tcpq_pkg::KEY_W-1:0]  threshold,
	input  wire logic                        res_ready,
	output tcpq_pkg::res_push_t              push
);

	import tcpq_pkg::*;

	logic [ADDR_W-1:0]  p_head_q, p_tail_q, n_head_q, n_tail_q;
	logic [OCC_W-1:0]   p_cnt_q, n_cnt_q, occ_q, total;
	logic               busy_q, sel_pri_q;
	logic               accept, is_enq, is_pri, full, empty, p_nonempty;
	logic               do_push, do_pop;
	logic [ENTRY_W-1:0] wdata, p_rdata, n_rdata, rdata;

	assign total      = p_cnt_q + n_cnt_q;
	assign full       = (total == OCC_W'(DEPTH));
	assign empty      = (total == '0);
	assign p_nonempty = (p_cnt_q != '0);
	assign is_enq     = (in_data.cmd == CMD_ENQUEUE);
	assign is_pri     = (in_data.item_key >= threshold);
	assign in_stall   = busy_q || !res_ready;
	assign accept     = in_valid && !in_stall;
	assign do_push    = accept && is_enq && !full;
	assign do_pop     = accept && !is_enq && !empty;
	assign wdata      = {in_data.item_key, in_data.item_tag};
	assign rdata      = sel_pri_q ? p_rdata : n_rdata;

	tcpq_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_pri_ram (
		.clk   (clk),
		.we    (do_push && is_pri),
		.waddr (p_tail_q),
		.wdata (wdata),
		.re    (do_pop && p_nonempty),
		.raddr (p_head_q),
		.rdata (p_rdata)
	);

	tcpq_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_nrm_ram (
		.clk   (clk),
		.we    (do_push && !is_pri),
		.waddr (n_tail_q),
		.wdata (wdata),
		.re    (do_pop && !p_nonempty),
		.raddr (n_head_q),
		.rdata (n_rdata)
	);

	always_comb begin
		push.valid          = busy_q || (accept && (is_enq || empty));
		push.item.status    = ST_EMPTY;
		push.item.out_tag   = '0;
		push.item.out_key   = '0;
		push.item.occupancy = total;
		if (busy_q) begin
			push.item.status    = ST_DEQUEUED;
			push.item.out_tag   = rdata[TAG_BITS-1:0];
			push.item.out_key   = rdata[ENTRY_W-1 -: KEY_W];
			push.item.occupancy = occ_q;
		end else if (is_enq) begin
			if (full) begin
				push.item.status = ST_FULL;
			end else begin
				push.item.status    = ST_ENQUEUED;
				push.item.occupancy = total + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_pop) begin
			sel_pri_q <= p_nonempty;
			occ_q     <= total - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_head_q <= '0;
			p_tail_q <= '0;
			n_head_q <= '0;
			n_tail_q <= '0;
			p_cnt_q  <= '0;
			n_cnt_q  <= '0;
			busy_q   <= 1'b0;
		end else begin
			busy_q <= do_pop;
			if (do_push) begin
				if (is_pri) begin
					p_tail_q <= next_ptr(p_tail_q);
					p_cnt_q  <= p_cnt_q + 1'b1;
				end else begin
					n_tail_q <= next_ptr(n_tail_q);
					n_cnt_q  <= n_cnt_q + 1'b1;
				end
			end
			if (do_pop) begin
				if (p_nonempty) begin
					p_head_q <= next_ptr(p_head_q);
					p_cnt_q  <= p_cnt_q - 1'b1;
				end else begin
					n_head_q <= next_ptr(n_head_q);
					n_cnt_q  <= n_cnt_q - 1'b1;
				end
			end
		end
	end

`ifndef SYNTH
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total <= OCC_W'(DEPTH))
		else $error("Entry count exceeds capacity.");

	a_busy_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> !busy_q)
		else $error("Dequeue read lasted more than one cycle.");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		do_push |=> total == $past(total) + 1'b1)
		else $error("Enqueue did not raise the entry count.");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop |=> total == $past(total) - 1'b1 && push.valid)
		else $error("Dequeue did not lower the entry count or return a result.");
`endif

endmodule

`default_nettype wire

### src/two_class_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Two-class queue with strict priority and FIFO order within each class. An enqueue
// whose key is at or above the threshold register joins the priority class; the rest
// join the normal class, and a dequeue takes the oldest priority entry before any
// normal one. Both classes share 16 entries, each class kept in its own RAM with separate
// read and write ports and a registered read. An enqueue's result is pushed as it is taken;
// a dequeue first waits for the registered RAM read of the head entry. One request is in
// work at a time. Results pass through a two-entry output queue, so a request is taken while
// one earlier result still waits. The threshold sits at byte address 0 and resets to
// 65; change it only while the block is idle.
module two_class_priority_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire tcpq_pkg::in_item_t   in_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output tcpq_pkg::out_item_t       out_data,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [2:0]           paddr,
	input  wire logic [31:0]          pwdata,
	output logic      [31:0]          prdata,
	output logic                      pready
);

	import tcpq_pkg::*;

	logic [KEY_W-1:0] threshold_q;
	logic             res_ready;
	res_push_t        push;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_THRESHOLD) ? {{(32 - KEY_W){1'b0}}, threshold_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_THRESHOLD) begin
			threshold_q <= pwdata[KEY_W-1:0];
		end
	end

	tcpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.threshold (threshold_q),
		.res_ready (res_ready),
		.push      (push)
	);

	tcpq_resq u_resq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.ready     (res_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

### sim/tb_two_class_priority_queue.sv
`timescale 1ns / 1ps

module tb_two_class_priority_queue;
	import tcpq_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 1150;
	localparam logic [2:0] THRESHOLD_ADDR = {REG_THRESHOLD, 2'b00};

	typedef struct packed {
		logic [KEY_W-1:0]    key;
		logic [TAG_BITS-1:0] tag;
	} entry_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	two_class_priority_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	entry_t           priority_entries[$];
	entry_t           normal_entries[$];
	logic [KEY_W-1:0] threshold_model;
	out_item_t        pending_responses[$];

	int  errors;
	int  cycle;
	int  requests_sent;
	int  threshold_writes;
	int  status_seen[4];
	int  stall_left;
	bit  quiet;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycle = 0;
		while (cycle < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle++;
		end
		$display("Timeout after %0d cycles, %0d responses outstanding", cycle,
			pending_responses.size());
		$display("Test completed with failures");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		if (errors < 40)
			$display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
				want);
		errors++;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic out_item_t compute_response(input in_item_t req);
		out_item_t rsp;
		entry_t    e;
		rsp = '0;
		if (req.cmd == CMD_ENQUEUE) begin
			if (priority_entries.size() + normal_entries.size() >= DEPTH) begin
				rsp.status = ST_FULL;
			end else begin
				e.key = req.item_key;
				e.tag = req.item_tag;
				if (req.item_key >= threshold_model)
					priority_entries.push_back(e);
				else
					normal_entries.push_back(e);
				rsp.status = ST_ENQUEUED;
			end
		end else if (priority_entries.size() != 0 || normal_entries.size() != 0) begin
			if (priority_entries.size() != 0)
				e = priority_entries.pop_front();
			else
				e = normal_entries.pop_front();
			rsp.status  = ST_DEQUEUED;
			rsp.out_tag = e.tag;
			rsp.out_key = e.key;
		end else begin
			rsp.status = ST_EMPTY;
		end
		rsp.occupancy = OCC_W'(priority_entries.size() + normal_entries.size());
		return rsp;
	endfunction

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_responses.size() == 0) begin
				report_mismatch("unexpected response", 32'(out_data), 32'h0);
			end else begin
				want = pending_responses.pop_front();
				status_seen[out_data.status]++;
				if (out_data.status !== want.status)
					report_mismatch("status", 32'(out_data.status), 32'(want.status));
				if (out_data.out_tag !== want.out_tag)
					report_mismatch("out_tag", 32'(out_data.out_tag), 32'(want.out_tag));
				if (out_data.out_key !== want.out_key)
					report_mismatch("out_key", 32'(out_data.out_key), 32'(want.out_key));
				if (out_data.occupancy !== want.occupancy)
					report_mismatch("occupancy", 32'(out_data.occupancy),
						32'(want.occupancy));
			end
		end
	end

	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (!quiet && $urandom_range(0, 99) < 25) begin
			out_stall <= 1'b1;
			stall_left = pick_gap();
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic send_request(input cmd_t cmd, input logic [KEY_W-1:0] key,
		input logic [TAG_BITS-1:0] tag);
		in_item_t req;
		int       gap;
		req.cmd      = cmd;
		req.item_key = key;
		req.item_tag = tag;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		do @(posedge clk); while (in_stall);
		pending_responses.push_back(compute_response(req));
		requests_sent++;
	endtask

	task automatic wait_drained();
		if (in_valid)
			in_valid <= 1'b0;
		while (pending_responses.size() != 0) @(posedge clk);
	endtask

	task automatic apb_transfer(input logic wr, input logic [31:0] wdata,
		output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= THRESHOLD_ADDR;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_threshold_readback();
		logic [31:0] rd;
		apb_transfer(1'b0, 32'h0, rd);
		if (rd !== 32'(threshold_model))
			report_mismatch("threshold readback", rd, 32'(threshold_model));
	endtask

	task automatic set_threshold(input logic [KEY_W-1:0] value);
		logic [31:0] rd;
		wait_drained();
		apb_transfer(1'b1, 32'(value), rd);
		threshold_model = value;
		threshold_writes++;
		check_threshold_readback();
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(0, 3))
			0: return (threshold_model == 0) ? '0 : threshold_model - 1'b1;
			1: return threshold_model;
			default: return KEY_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic test_order_and_empty();
		check_threshold_readback();
		send_request(CMD_DEQUEUE, 8'hff, 16'hffff);
		send_request(CMD_ENQUEUE, 8'd64, 16'h0000);
		send_request(CMD_ENQUEUE, 8'd65, 16'hffff);
		send_request(CMD_ENQUEUE, 8'd255, 16'h5aa5);
		send_request(CMD_ENQUEUE, 8'd0, 16'ha55a);
	endtask

	task automatic test_threshold_keeps_class();
		set_threshold(8'd0);
		send_request(CMD_ENQUEUE, 8'd0, 16'h0001);
		set_threshold(8'd255);
		send_request(CMD_ENQUEUE, 8'd254, 16'h0002);
		send_request(CMD_ENQUEUE, 8'd255, 16'h0003);
	endtask

	task automatic test_full_queue();
		while (priority_entries.size() + normal_entries.size() < DEPTH)
			send_request(CMD_ENQUEUE, KEY_W'($urandom_range(250, 255)),
				TAG_BITS'($urandom));
		send_request(CMD_ENQUEUE, 8'hff, 16'hffff);
		repeat (4)
			send_request(CMD_DEQUEUE, KEY_W'($urandom), TAG_BITS'($urandom));
	endtask

	task automatic test_random_traffic();
		int done;
		int phase_len;
		int enq_pct;
		done = 0;
		while (done < RANDOM_ITEMS) begin
			wait_drained();
			quiet = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 3))
					0: set_threshold(8'd0);
					1: set_threshold(8'd255);
					2: set_threshold(THRESHOLD_RESET);
					default: set_threshold(KEY_W'($urandom_range(0, 255)));
				endcase
			end
			case ($urandom_range(0, 2))
				0: enq_pct = 15;
				1: enq_pct = 50;
				default: enq_pct = 85;
			endcase
			phase_len = $urandom_range(20, 80);
			repeat (phase_len) begin
				if ($urandom_range(0, 99) < enq_pct)
					send_request(CMD_ENQUEUE, pick_key(), TAG_BITS'($urandom));
				else
					send_request(CMD_DEQUEUE, KEY_W'($urandom), TAG_BITS'($urandom));
				done++;
			end
		end
		quiet = 1'b0;
	endtask

	initial begin
		errors           = 0;
		requests_sent    = 0;
		threshold_writes = 0;
		stall_left       = 0;
		quiet            = 1'b0;
		threshold_model  = THRESHOLD_RESET;
		status_seen      = '{default: 0};
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		out_stall <= 1'b0;
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		paddr     <= '0;
		pwdata    <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_order_and_empty();
		test_threshold_keeps_class();
		test_full_queue();
		test_random_traffic();

		wait_drained();
		repeat (10) @(posedge clk);
		$display("Covered %0d requests over %0d threshold settings.", requests_sent,
			threshold_writes + 1);
		$display("Responses: %0d enqueued, %0d dequeued, %0d empty, %0d full.",
			status_seen[ST_ENQUEUED], status_seen[ST_DEQUEUED], status_seen[ST_EMPTY],
			status_seen[ST_FULL]);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
